// File: src/rvenc_pkg.sv
// Package for the RV64IM instruction encoder: item types, mnemonic codes,
// opcodes, status and relocation codes, funct tables and format helpers.
// Has no dependencies of its own.
`default_nettype none

package rvenc_pkg;

    typedef struct packed {
        logic [5:0]         cmd;
        logic [4:0]         rd;
        logic [4:0]         rs1;
        logic [4:0]         rs2;
        logic signed [31:0] imm;
        logic [31:0]        current_offset;
        logic [31:0]        target_offset;
        logic               target_ok;
    } t_enc_in;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  status;
        logic [1:0]  reloc_kind;
        logic        last;
    } t_enc_out;

    // Mnemonic codes.
    localparam logic [5:0] CMD_RET   = 6'd0;
    localparam logic [5:0] CMD_NOP   = 6'd1;
    localparam logic [5:0] CMD_MV    = 6'd2;
    localparam logic [5:0] CMD_JR    = 6'd3;
    localparam logic [5:0] CMD_SNEZ  = 6'd4;
    localparam logic [5:0] CMD_SEQZ  = 6'd5;
    localparam logic [5:0] CMD_NEG   = 6'd6;
    localparam logic [5:0] CMD_LI    = 6'd7;
    localparam logic [5:0] CMD_CALL  = 6'd8;
    localparam logic [5:0] CMD_LA    = 6'd9;
    localparam logic [5:0] CMD_LUI   = 6'd10;
    localparam logic [5:0] CMD_AUIPC = 6'd11;
    localparam logic [5:0] CMD_ADDI  = 6'd12;
    localparam logic [5:0] CMD_ADDIW = 6'd13;
    localparam logic [5:0] CMD_SLTIU = 6'd18;
    localparam logic [5:0] CMD_SLLI  = 6'd19;
    localparam logic [5:0] CMD_SRAI  = 6'd21;
    localparam logic [5:0] CMD_ADD   = 6'd22;
    localparam logic [5:0] CMD_REMU  = 6'd37;
    localparam logic [5:0] CMD_LB    = 6'd38;
    localparam logic [5:0] CMD_LD    = 6'd44;
    localparam logic [5:0] CMD_SB    = 6'd45;
    localparam logic [5:0] CMD_SD    = 6'd48;
    localparam logic [5:0] CMD_JALR  = 6'd49;
    localparam logic [5:0] CMD_J     = 6'd50;
    localparam logic [5:0] CMD_BEQ   = 6'd51;
    localparam logic [5:0] CMD_BEQZ  = 6'd57;
    localparam logic [5:0] CMD_BNEZ  = 6'd58;

    // Major opcodes.
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_IMMW   = 7'h1b;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_LOAD   = 7'h03;

    localparam logic [31:0] CALL_HEAD = 32'h0000_0097;
    localparam logic [31:0] SRA_BIT   = 32'h4000_0000;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;

    // Status codes.
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_IMM    = 3'd1;
    localparam logic [2:0] ST_SHIFT  = 3'd2;
    localparam logic [2:0] ST_BRANCH = 3'd3;
    localparam logic [2:0] ST_JUMP   = 3'd4;
    localparam logic [2:0] ST_UNRES  = 3'd5;
    localparam logic [2:0] ST_UNSUP  = 3'd6;

    // Relocation kinds.
    localparam logic [1:0] RK_NONE     = 2'd0;
    localparam logic [1:0] RK_CALL_PLT = 2'd1;
    localparam logic [1:0] RK_PCREL_HI = 2'd2;
    localparam logic [1:0] RK_PCREL_LO = 2'd3;

    localparam logic [2:0] IALU_F3 [7] = '{3'd0, 3'd0, 3'd7, 3'd6, 3'd4, 3'd2, 3'd3};
    localparam logic [2:0] REG_F3 [16] = '{3'd0, 3'd0, 3'd1, 3'd5, 3'd7, 3'd6, 3'd4, 3'd2,
                                           3'd3, 3'd0, 3'd1, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
    localparam logic [6:0] REG_F7 [16] = '{7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00,
                                           7'h00, 7'h00, 7'h00, 7'h01, 7'h01, 7'h01,
                                           7'h01, 7'h01, 7'h01, 7'h01};
    localparam logic [2:0] LOAD_F3 [7] = '{3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3};
    localparam logic [2:0] BR_F3 [8]   = '{3'd0, 3'd1, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1};

    function automatic logic [31:0] form_r(logic [6:0] op, logic [4:0] rd, logic [2:0] f3,
                                           logic [4:0] rs1, logic [4:0] rs2,
                                           logic [6:0] f7);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] form_i(logic [6:0] op, logic [4:0] rd, logic [2:0] f3,
                                           logic [4:0] rs1, logic [11:0] imm);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] form_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                           logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] form_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                           logic [12:0] off);
        return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] form_j(logic [4:0] rd, logic [20:0] off);
        return {off[20], off[10:1], off[11], off[19:12], rd, OP_JAL};
    endfunction

    function automatic logic [31:0] form_u(logic [6:0] op, logic [4:0] rd, logic [19:0] imm);
        return {imm, rd, op};
    endfunction

endpackage

`default_nettype wire

// File: src/riscv_instruction_encoder_core.sv
// Top level of the RV64IM instruction encoder: a three-stage pipeline that
// turns one assembly operation into one or two instruction words.
// Depends on rvenc_pkg for item types, codes and format helpers.
//
// Usage:
//   Input channel i_valid / o_stall / i_data carries one operation per item.
//   Output channel o_valid / i_stall / o_data carries one instruction word
//   per item, with status, relocation kind and a last flag.
//   An accepted operation moves through the stage 1, stage 2 and stage 3
//   registers, and stage 3 drives the output. A new operation can be
//   accepted every cycle while o_stall is low.
//   li with a wide constant, call and la give two words, and hold the output
//   register until both are taken; everything else, errors included, gives one.
//   Stage 1 registers the operation, stage 2 holds the displacement and
//   range checks, stage 3 holds the encoded words and their word counter.
//   Each stage carries its own valid bit and empty stages are filled while
//   later ones wait, so a stalled receiver loses and repeats nothing.
//   o_stall rises only when every stage is full and the output cannot move.
//   Reset clears all valid bits; the pipeline is empty afterwards.
`default_nettype none

module riscv_instruction_encoder_core (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_stall,
    input  rvenc_pkg::t_enc_in      i_data,
    output logic                    o_valid,
    input  wire                     i_stall,
    output rvenc_pkg::t_enc_out     o_data
);
    import rvenc_pkg::*;

    // Stage 1: registered operation.
    logic        r1_v;
    t_enc_in     r1_d;

    // Stage 2: operation fields and precomputed checks.
    logic        r2_v;
    logic [5:0]  r2_cmd;
    logic [4:0]  r2_rd;
    logic [4:0]  r2_rs1;
    logic [4:0]  r2_rs2;
    logic [19:0] r2_imm20;
    logic [19:0] r2_hi20;
    logic        r2_imm12;
    logic        r2_shamt_ok;
    logic        r2_tok;
    logic        r2_br_ok;
    logic        r2_j_ok;
    logic [20:0] r2_disp;

    // Stage 3: encoded words.
    logic        r3_v;
    logic [31:0] r3_w0;
    logic [31:0] r3_w1;
    logic [2:0]  r3_st;
    logic [1:0]  r3_rk0;
    logic [1:0]  r3_rk1;
    logic        r3_two;
    logic        r3_phase;

    logic        free3;
    logic        rdy1;
    logic        rdy2;
    logic        rdy3;

    logic [32:0] disp;
    logic [31:0] hi_sum;
    logic        n_imm12;
    logic        n_shamt_ok;
    logic        n_br_ok;
    logic        n_j_ok;

    logic [31:0] n_w0;
    logic [31:0] n_w1;
    logic [2:0]  n_st;
    logic [1:0]  n_rk0;
    logic [1:0]  n_rk1;
    logic        n_two;
    logic [2:0]  ialu_idx;
    logic [3:0]  reg_idx;
    logic [2:0]  load_idx;
    logic [2:0]  br_idx;
    logic [1:0]  st_f3;
    logic [4:0]  b_rs2;
    logic [11:0] imm12v;

    // Output stage is freed once its final word is taken.
    assign free3   = r3_v && !i_stall && (!r3_two || r3_phase);
    assign rdy3    = !r3_v || free3;
    assign rdy2    = !r2_v || rdy3;
    assign rdy1    = !r1_v || rdy2;
    assign o_stall = !rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (rdy1) begin
            r1_v <= i_valid;
        end
        if (rdy1) begin
            r1_d <= i_data;
        end
    end

    // Displacement is taken over 33 bits so that the range checks see the true sign.
    assign disp       = {1'b0, r1_d.target_offset} - {1'b0, r1_d.current_offset};
    assign hi_sum     = r1_d.imm + 32'h0000_0800;
    assign n_imm12    = (r1_d.imm[31:11] == '0) || (r1_d.imm[31:11] == '1);
    assign n_shamt_ok = (r1_d.imm[31:6] == '0);
    assign n_br_ok    = !disp[0] && ((disp[32:12] == '0) || (disp[32:12] == '1));
    assign n_j_ok     = !disp[0] && ((disp[32:20] == '0) || (disp[32:20] == '1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (rdy2) begin
            r2_v <= r1_v;
        end
        if (rdy2) begin
            r2_cmd      <= r1_d.cmd;
            r2_rd       <= r1_d.rd;
            r2_rs1      <= r1_d.rs1;
            r2_rs2      <= r1_d.rs2;
            r2_imm20    <= r1_d.imm[19:0];
            r2_hi20     <= hi_sum[31:12];
            r2_imm12    <= n_imm12;
            r2_shamt_ok <= n_shamt_ok;
            r2_tok      <= r1_d.target_ok;
            r2_br_ok    <= n_br_ok;
            r2_j_ok     <= n_j_ok;
            r2_disp     <= disp[20:0];
        end
    end

    assign ialu_idx = 3'(r2_cmd - CMD_ADDI);
    assign reg_idx  = 4'(r2_cmd - CMD_ADD);
    assign load_idx = 3'(r2_cmd - CMD_LB);
    assign br_idx   = 3'(r2_cmd - CMD_BEQ);
    assign st_f3    = 2'(r2_cmd - CMD_SB);
    assign b_rs2    = (r2_cmd >= CMD_BEQZ) ? REG_ZERO : r2_rs2;
    assign imm12v   = r2_imm20[11:0];

    always_comb begin
        n_w0  = '0;
        n_w1  = '0;
        n_st  = ST_OK;
        n_rk0 = RK_NONE;
        n_rk1 = RK_NONE;
        n_two = 1'b0;
        unique case (r2_cmd) inside
            CMD_RET:   n_w0 = form_i(OP_JALR, REG_ZERO, 3'd0, REG_RA, 12'd0);
            CMD_NOP:   n_w0 = form_i(OP_IMM, REG_ZERO, 3'd0, REG_ZERO, 12'd0);
            CMD_MV:    n_w0 = form_i(OP_IMM, r2_rd, 3'd0, r2_rs1, 12'd0);
            CMD_JR:    n_w0 = form_i(OP_JALR, REG_ZERO, 3'd0, r2_rs1, 12'd0);
            CMD_SNEZ:  n_w0 = form_r(OP_REG, r2_rd, 3'd3, REG_ZERO, r2_rs1, 7'h00);
            CMD_SEQZ:  n_w0 = form_i(OP_IMM, r2_rd, 3'd3, r2_rs1, 12'd1);
            CMD_NEG:   n_w0 = form_r(OP_REG, r2_rd, 3'd0, REG_ZERO, r2_rs1, 7'h20);
            CMD_LI: begin
                if (r2_imm12) begin
                    n_w0 = form_i(OP_IMM, r2_rd, 3'd0, REG_ZERO, imm12v);
                end else begin
                    n_w0  = form_u(OP_LUI, r2_rd, r2_hi20);
                    n_w1  = form_i(OP_IMMW, r2_rd, 3'd0, r2_rd, imm12v);
                    n_two = 1'b1;
                end
            end
            CMD_CALL: begin
                n_w0  = CALL_HEAD;
                n_w1  = form_i(OP_JALR, REG_RA, 3'd0, REG_RA, 12'd0);
                n_rk0 = RK_CALL_PLT;
                n_two = 1'b1;
            end
            CMD_LA: begin
                n_w0  = form_u(OP_AUIPC, r2_rd, 20'd0);
                n_w1  = form_i(OP_IMM, r2_rd, 3'd0, r2_rd, 12'd0);
                n_rk0 = RK_PCREL_HI;
                n_rk1 = RK_PCREL_LO;
                n_two = 1'b1;
            end
            CMD_LUI:   n_w0 = form_u(OP_LUI, r2_rd, r2_imm20);
            CMD_AUIPC: n_w0 = form_u(OP_AUIPC, r2_rd, r2_imm20);
            [CMD_ADDI:CMD_SLTIU]: begin
                if (!r2_imm12) begin
                    n_st = ST_IMM;
                end else begin
                    n_w0 = form_i((r2_cmd == CMD_ADDIW) ? OP_IMMW : OP_IMM, r2_rd,
                                  IALU_F3[ialu_idx], r2_rs1, imm12v);
                end
            end
            [CMD_SLLI:CMD_SRAI]: begin
                if (!r2_shamt_ok) begin
                    n_st = ST_SHIFT;
                end else begin
                    n_w0 = form_i(OP_IMM, r2_rd, (r2_cmd == CMD_SLLI) ? 3'd1 : 3'd5,
                                  r2_rs1, imm12v)
                         | ((r2_cmd == CMD_SRAI) ? SRA_BIT : 32'd0);
                end
            end
            [CMD_ADD:CMD_REMU]: begin
                n_w0 = form_r(OP_REG, r2_rd, REG_F3[reg_idx], r2_rs1, r2_rs2,
                              REG_F7[reg_idx]);
            end
            [CMD_LB:CMD_LD]: begin
                if (!r2_imm12) begin
                    n_st = ST_IMM;
                end else begin
                    n_w0 = form_i(OP_LOAD, r2_rd, LOAD_F3[load_idx], r2_rs1, imm12v);
                end
            end
            [CMD_SB:CMD_SD]: begin
                if (!r2_imm12) begin
                    n_st = ST_IMM;
                end else begin
                    n_w0 = form_s({1'b0, st_f3}, r2_rs1, r2_rs2, imm12v);
                end
            end
            CMD_JALR: begin
                if (!r2_imm12) begin
                    n_st = ST_IMM;
                end else begin
                    n_w0 = form_i(OP_JALR, r2_rd, 3'd0, r2_rs1, imm12v);
                end
            end
            CMD_J: begin
                if (!r2_tok) begin
                    n_st = ST_UNRES;
                end else if (!r2_j_ok) begin
                    n_st = ST_JUMP;
                end else begin
                    n_w0 = form_j(REG_ZERO, r2_disp);
                end
            end
            [CMD_BEQ:CMD_BNEZ]: begin
                if (!r2_tok) begin
                    n_st = ST_UNRES;
                end else if (!r2_br_ok) begin
                    n_st = ST_BRANCH;
                end else begin
                    n_w0 = form_b(BR_F3[br_idx], r2_rs1, b_rs2, r2_disp[12:0]);
                end
            end
            default:   n_st = ST_UNSUP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v     <= 1'b0;
            r3_phase <= 1'b0;
        end else if (rdy3) begin
            r3_v     <= r2_v;
            r3_phase <= 1'b0;
        end else if (!i_stall) begin
            // First word of a two-word item has been taken.
            r3_phase <= 1'b1;
        end
        if (rdy3) begin
            r3_w0  <= n_w0;
            r3_w1  <= n_w1;
            r3_st  <= n_st;
            r3_rk0 <= n_rk0;
            r3_rk1 <= n_rk1;
            r3_two <= n_two;
        end
    end

    assign o_valid           = r3_v;
    assign o_data.word       = r3_phase ? r3_w1 : r3_w0;
    assign o_data.status     = r3_st;
    assign o_data.reloc_kind = r3_phase ? r3_rk1 : r3_rk0;
    assign o_data.last       = !r3_two || r3_phase;

endmodule

`default_nettype wire
